[sv/pscs_pkg.sv]
// Package for the particle sphere collide step core.
// Shared widths, default register values, register indices and a saturation helper; no dependencies.
package pscs_pkg;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned DataW       = 32;
  localparam int unsigned RadW        = 31;
  localparam int unsigned DtW         = 17;
  localparam int unsigned CfgIdxW     = 3;
  localparam logic [RadW-1:0] RadiusRst = 31'd327680;
  localparam logic [DtW-1:0]  DtRst     = 17'd1092;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCenterX = 3'd0,
    CfgCenterY = 3'd1,
    CfgCenterZ = 3'd2,
    CfgRadius  = 3'd3,
    CfgStep    = 3'd4
  } cfg_idx_e;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage

[sv/particle_sphere_collide_step_core.sv]
// Top level: one explicit Euler step of a particle against a sphere.
// Pipeline: 133 register stages (distance, 32-stage sqrt, 48-stage impulse divide,
// 48-stage normal divides, scale and integrate). Throughput: one request per
// cycle, a stall freezes the whole pipe. Reset (rst_ni low, async) clears valid
// bits and restores the configuration registers.
module particle_sphere_collide_step_core #(
  parameter int unsigned FRAC_BITS = pscs_pkg::FracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [31:0] pos_x_i, pos_y_i, pos_z_i,
  input  logic signed [31:0] vel_x_i, vel_y_i, vel_z_i,
  input  logic signed [31:0] acc_x_i, acc_y_i, acc_z_i,
  input  logic [30:0] mass_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] new_pos_x_o, new_pos_y_o, new_pos_z_o,
  output logic signed [31:0] new_vel_x_o, new_vel_y_o, new_vel_z_o,
  output logic        hit_o
);
  localparam int unsigned LSQ = 32;
  localparam int unsigned LDV = 32 + FRAC_BITS;
  localparam int unsigned LAT = 2 + LSQ + LDV + LDV + 3;

  logic signed [31:0] cx_q, cy_q, cz_q;
  logic [30:0] rad_q;
  logic [16:0] dt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0; cy_q <= '0; cz_q <= '0;
      rad_q <= pscs_pkg::RadiusRst;
      dt_q <= pscs_pkg::DtRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pscs_pkg::CfgCenterX: cx_q <= cfg_data_i;
        pscs_pkg::CfgCenterY: cy_q <= cfg_data_i;
        pscs_pkg::CfgCenterZ: cz_q <= cfg_data_i;
        pscs_pkg::CfgRadius:  rad_q <= cfg_data_i[30:0];
        pscs_pkg::CfgStep:    dt_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // global stall: pipe advances when output slot free or taken
  logic en;
  logic [LAT-1:0] v_q;
  assign en = !v_q[LAT-1] || out_ready_i;
  assign in_ready_o = en;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en) v_q <= {v_q[LAT-2:0], in_valid_i};
  end
  assign out_valid_o = v_q[LAT-1];

  typedef struct packed {
    logic signed [31:0] px, py, pz, vx, vy, vz, ax, ay, az;
    logic signed [32:0] dx, dy, dz;
    logic [30:0] mass;
    logic ok;
  } it_t;

  // stage 1: differences
  it_t s1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q.px <= pos_x_i; s1_q.py <= pos_y_i; s1_q.pz <= pos_z_i;
      s1_q.vx <= vel_x_i; s1_q.vy <= vel_y_i; s1_q.vz <= vel_z_i;
      s1_q.ax <= acc_x_i; s1_q.ay <= acc_y_i; s1_q.az <= acc_z_i;
      s1_q.mass <= mass_i;
      s1_q.dx <= 33'(pos_x_i) - 33'(cx_q);
      s1_q.dy <= 33'(pos_y_i) - 33'(cy_q);
      s1_q.dz <= 33'(pos_z_i) - 33'(cz_q);
      s1_q.ok <= 1'b0;
    end
  end

  function automatic logic [32:0] mg(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : v;
  endfunction

  logic [32:0] mx, my, mz;
  assign mx = mg(s1_q.dx);
  assign my = mg(s1_q.dy);
  assign mz = mg(s1_q.dz);

  // stage 2: squares and hit test
  it_t s2_q, s2_d;
  logic [63:0] sum_q;
  always_comb begin
    s2_d = s1_q;
    s2_d.ok = !(mx[32] || mx[31] || my[32] || my[31] || mz[32] || mz[31]) &&
              (66'(mx[30:0]*mx[30:0]) + 66'(my[30:0]*my[30:0]) +
               66'(mz[30:0]*mz[30:0]) <= 66'(rad_q*rad_q));
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q <= s2_d;
      sum_q <= 64'(mx[30:0]*mx[30:0]) + 64'(my[30:0]*my[30:0]) +
               64'(mz[30:0]*mz[30:0]);
    end
  end

  // sqrt: one result bit per stage
  logic [63:0] sx_q [LSQ+1];
  logic [31:0] sr_q [LSQ+1];
  it_t         si_q [LSQ+1];
  always_comb begin
    sx_q[0] = sum_q; sr_q[0] = '0; si_q[0] = s2_q;
  end
  for (genvar k = 0; k < LSQ; k++) begin : g_sq
    localparam int unsigned B = 2*(LSQ-1-k);
    logic [63:0] trial;
    assign trial = ({32'b0, sr_q[k]} << (LSQ-k)) | (64'd1 << B);
    always_ff @(posedge clk_i) begin
      if (en) begin
        si_q[k+1] <= si_q[k];
        if (sx_q[k] >= trial) begin
          sx_q[k+1] <= sx_q[k] - trial;
          sr_q[k+1] <= sr_q[k] | (32'd1 << (LSQ-1-k));
        end else begin
          sx_q[k+1] <= sx_q[k];
          sr_q[k+1] <= sr_q[k];
        end
      end
    end
  end

  logic [31:0] root;
  it_t         t3;
  assign root = sr_q[LSQ];
  assign t3   = si_q[LSQ];

  // impulse divide; zero mass yields all ones, saturated later
  localparam int unsigned SIDE1 = $bits(it_t) + 32;
  logic [LDV-1:0] inum;
  logic [SIDE1-1:0] side1_o;
  logic [LDV-1:0] imp_raw;
  assign inum = LDV'({1'b0, rad_q} - {1'b0, root[30:0]}) << (FRAC_BITS + 1);
  pscs_div #(.NW(LDV), .DW(31), .SW(SIDE1)) u_idiv (
    .clk_i, .en_i(en), .num_i(inum), .den_i(t3.mass),
    .side_i({t3, root}), .quo_o(imp_raw), .side_o(side1_o)
  );

  it_t t4;
  logic [31:0] dist4;
  logic [30:0] imp;
  assign {t4, dist4} = side1_o;
  assign imp = (imp_raw > LDV'(32'h7fffffff)) ? 31'h7fffffff : imp_raw[30:0];

  // normal divides, one per axis
  localparam int unsigned SIDE2 = $bits(it_t) + 31 + 1;
  logic [LDV-1:0] nq [3];
  logic [SIDE2-1:0] side2 [3];
  logic [32:0] dm [3];
  assign dm[0] = mg(t4.dx);
  assign dm[1] = mg(t4.dy);
  assign dm[2] = mg(t4.dz);
  for (genvar a = 0; a < 3; a++) begin : g_nd
    pscs_div #(.NW(LDV), .DW(32), .SW(SIDE2)) u_ndiv (
      .clk_i, .en_i(en), .num_i(LDV'(dm[a][30:0]) << FRAC_BITS),
      .den_i(dist4), .side_i({t4, imp, dist4 == '0}),
      .quo_o(nq[a]), .side_o(side2[a])
    );
  end

  it_t t5;
  logic [30:0] imp5;
  logic dz5;
  assign {t5, imp5, dz5} = side2[0];

  // stage: impulse times normal
  logic signed [31:0] v6_q [3];
  it_t t6_q;
  logic signed [31:0] vin [3];
  logic sgn [3];
  assign vin[0] = t5.vx; assign vin[1] = t5.vy; assign vin[2] = t5.vz;
  assign sgn[0] = t5.dx[32]; assign sgn[1] = t5.dy[32]; assign sgn[2] = t5.dz[32];
  for (genvar a = 0; a < 3; a++) begin : g_dv
    logic [63:0] pr;
    logic signed [65:0] dv;
    assign pr = (64'(imp5) * 64'(nq[a][32:0])) >> FRAC_BITS;
    assign dv = sgn[a] ? -$signed({2'b0, pr}) : $signed({2'b0, pr});
    always_ff @(posedge clk_i) begin
      if (en) v6_q[a] <= (t5.ok && !dz5) ? pscs_pkg::sat32(66'(vin[a]) + dv) : vin[a];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) t6_q <= t5;
  end

  // stage: integrate products
  logic signed [32:0] p7_q [3], q7_q [3];
  logic signed [31:0] pp7_q [3], vv7_q [3];
  logic h7_q;
  logic signed [31:0] pin [3], ain [3];
  assign pin[0] = t6_q.px; assign pin[1] = t6_q.py; assign pin[2] = t6_q.pz;
  assign ain[0] = t6_q.ax; assign ain[1] = t6_q.ay; assign ain[2] = t6_q.az;
  for (genvar a = 0; a < 3; a++) begin : g_in
    logic signed [49:0] m1, m2;
    assign m1 = 50'(v6_q[a]) * $signed({1'b0, dt_q});
    assign m2 = 50'(ain[a]) * $signed({1'b0, dt_q});
    always_ff @(posedge clk_i) begin
      if (en) begin
        p7_q[a] <= 33'(m1[49] ? -((-m1) >>> FRAC_BITS) : (m1 >>> FRAC_BITS));
        q7_q[a] <= 33'(m2[49] ? -((-m2) >>> FRAC_BITS) : (m2 >>> FRAC_BITS));
        pp7_q[a] <= pin[a];
        vv7_q[a] <= v6_q[a];
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) h7_q <= t6_q.ok;
  end

  // output register
  logic signed [31:0] np_q [3], nv_q [3];
  logic hit_q;
  for (genvar a = 0; a < 3; a++) begin : g_o
    always_ff @(posedge clk_i) begin
      if (en) begin
        np_q[a] <= pscs_pkg::sat32(66'(pp7_q[a]) + 66'(p7_q[a]));
        nv_q[a] <= pscs_pkg::sat32(66'(vv7_q[a]) + 66'(q7_q[a]));
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) hit_q <= h7_q;
  end

  assign new_pos_x_o = np_q[0]; assign new_pos_y_o = np_q[1];
  assign new_pos_z_o = np_q[2];
  assign new_vel_x_o = nv_q[0]; assign new_vel_y_o = nv_q[1];
  assign new_vel_z_o = nv_q[2];
  assign hit_o = hit_q;

  ap_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(new_pos_x_o))
    else $error("stalled result changed");
  ap_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o) else $error("ready low with empty output");
  ap_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[LSQ+1] && t3.ok |-> root <= 32'(rad_q))
    else $error("distance exceeds radius on hit");
endmodule

[sv/pscs_div.sv]
// Pipelined restoring divider: one quotient bit per stage, NW stages.
// Depends on nothing; stall by enable.
module pscs_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 32,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] side_o
);
  logic [NW-1:0] n_q [NW+1];
  logic [DW:0]   r_q [NW+1];
  logic [DW-1:0] d_q [NW+1];
  logic [SW-1:0] s_q [NW+1];

  always_comb begin
    n_q[0] = num_i;
    r_q[0] = '0;
    d_q[0] = den_i;
    s_q[0] = side_i;
  end

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic [DW+1:0] sh;
    logic [DW+1:0] df;
    assign sh = {r_q[k], n_q[k][NW-1]};
    assign df = sh - {2'b0, d_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k+1] <= {n_q[k][NW-2:0], ~df[DW+1]};
        r_q[k+1] <= df[DW+1] ? sh[DW:0] : df[DW:0];
        d_q[k+1] <= d_q[k];
        s_q[k+1] <= s_q[k];
      end
    end
  end

  assign quo_o  = n_q[NW];
  assign side_o = s_q[NW];
endmodule

[test/tb_top.sv]
// Testbench for particle_sphere_collide_step_core: one Euler step against a sphere.
// Drives random and directed particles, predicts each result, checks in order.
// Depends on pscs_pkg and the core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LatencyCycles = 186;
  localparam int unsigned WatchdogLimit = 20000;

  typedef struct packed {
    logic signed [31:0] px, py, pz, vx, vy, vz, ax, ay, az;
    logic [30:0] mass;
  } particle_t;

  typedef struct packed {
    logic signed [31:0] px, py, pz, vx, vy, vz;
    logic hit;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [31:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic signed [31:0] acc_x_i = '0, acc_y_i = '0, acc_z_i = '0;
  logic [30:0] mass_i = 31'd1;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] new_pos_x_o, new_pos_y_o, new_pos_z_o;
  logic signed [31:0] new_vel_x_o, new_vel_y_o, new_vel_z_o;
  logic hit_o;

  particle_sphere_collide_step_core uut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // sphere and step shadow registers
  logic signed [63:0] ctr_q [3];
  logic [63:0] radius_q, dt_q;

  step_t steps_q[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit rx_hold = 1'b0;
  bit rx_hold_long = 1'b0;

  function automatic logic signed [63:0] sat_q(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic [63:0] p;
    p = (abs64(a) * abs64(b)) >> pscs_pkg::FracBits;
    return ((a < 0) != (b < 0)) ? -$signed(p) : $signed(p);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic step_t euler_collide(input particle_t p);
    logic signed [63:0] pos [3], vel [3], acc [3], d [3], np, nv, nrm;
    logic [63:0] sum, root, imp, nm;
    bit far_axis;
    step_t r;
    pos[0] = p.px; pos[1] = p.py; pos[2] = p.pz;
    vel[0] = p.vx; vel[1] = p.vy; vel[2] = p.vz;
    acc[0] = p.ax; acc[1] = p.ay; acc[2] = p.az;
    far_axis = 1'b0;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = pos[i] - ctr_q[i];
      if (abs64(d[i]) >= 64'h8000_0000) far_axis = 1'b1;
    end
    if (!far_axis) begin
      sum = 0;
      for (int i = 0; i < 3; i++) sum = sum + abs64(d[i]) * abs64(d[i]);
      if (sum <= radius_q * radius_q) begin
        r.hit = 1'b1;
        root = int_sqrt(sum);
        if (p.mass == 0) imp = 64'd2147483647;
        else begin
          imp = ((2 * (radius_q - root)) << pscs_pkg::FracBits) / p.mass;
          if (imp > 64'd2147483647) imp = 64'd2147483647;
        end
        if (root != 0) begin
          for (int i = 0; i < 3; i++) begin
            nm = (abs64(d[i]) << pscs_pkg::FracBits) / root;
            nrm = d[i] < 0 ? -$signed(nm) : $signed(nm);
            vel[i] = sat_q(vel[i] + fx_mul($signed(imp), nrm));
          end
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      np = sat_q(pos[i] + fx_mul(vel[i], $signed(dt_q)));
      nv = sat_q(vel[i] + fx_mul(acc[i], $signed(dt_q)));
      case (i)
        0: begin r.px = np[31:0]; r.vx = nv[31:0]; end
        1: begin r.py = np[31:0]; r.vy = nv[31:0]; end
        default: begin r.pz = np[31:0]; r.vz = nv[31:0]; end
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // result checker and receiver stalls
  initial begin
    int unsigned wait_n;
    step_t e;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (steps_q.size() == 0) report_mismatch("unexpected result", 0, 0);
        else begin
          e = steps_q.pop_front();
          if (new_pos_x_o !== e.px) report_mismatch("new_pos_x", new_pos_x_o, e.px);
          if (new_pos_y_o !== e.py) report_mismatch("new_pos_y", new_pos_y_o, e.py);
          if (new_pos_z_o !== e.pz) report_mismatch("new_pos_z", new_pos_z_o, e.pz);
          if (new_vel_x_o !== e.vx) report_mismatch("new_vel_x", new_vel_x_o, e.vx);
          if (new_vel_y_o !== e.vy) report_mismatch("new_vel_y", new_vel_y_o, e.vy);
          if (new_vel_z_o !== e.vz) report_mismatch("new_vel_z", new_vel_z_o, e.vz);
          if (hit_o !== e.hit) report_mismatch("hit", hit_o, e.hit);
        end
        wait_n = rx_hold ? 0 : $urandom_range(0, 14);
        if (wait_n != 0 && !rx_hold_long) begin
          out_ready_i <= 1'b0;
          repeat (wait_n) @(posedge clk_i);
        end
        out_ready_i <= !rx_hold_long;
      end else if (!rx_hold_long && !out_ready_i) begin
        out_ready_i <= 1'b1;
      end else if (rx_hold_long) begin
        out_ready_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  initial begin
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic write_reg(input pscs_pkg::cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      pscs_pkg::CfgCenterX: ctr_q[0] = $signed(val);
      pscs_pkg::CfgCenterY: ctr_q[1] = $signed(val);
      pscs_pkg::CfgCenterZ: ctr_q[2] = $signed(val);
      pscs_pkg::CfgRadius:  radius_q = val[pscs_pkg::RadW-1:0];
      pscs_pkg::CfgStep:    dt_q = val[pscs_pkg::DtW-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (steps_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_sphere(input logic [31:0] cx, cy, cz, rad, dt);
    drain();
    write_reg(pscs_pkg::CfgCenterX, cx);
    write_reg(pscs_pkg::CfgCenterY, cy);
    write_reg(pscs_pkg::CfgCenterZ, cz);
    write_reg(pscs_pkg::CfgRadius, rad);
    write_reg(pscs_pkg::CfgStep, dt);
    cfg_we_i <= 1'b0;
  endtask

  // one request; gap drawn before it unless no_gap
  task automatic send_particle(input particle_t p, input bit no_gap = 1'b0);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {pos_x_i, pos_y_i, pos_z_i} <= {p.px, p.py, p.pz};
    {vel_x_i, vel_y_i, vel_z_i} <= {p.vx, p.vy, p.vz};
    {acc_x_i, acc_y_i, acc_z_i} <= {p.ax, p.ay, p.az};
    mass_i <= p.mass;
    do @(posedge clk_i); while (!in_ready_o);
    steps_q.insert(steps_q.size(), euler_collide(p));
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
      default: return $urandom();
    endcase
  endfunction

  // random particles; with near set, placed close to the sphere center
  function automatic particle_t rand_particle(input bit near);
    particle_t p;
    p.px = rand_word(); p.py = rand_word(); p.pz = rand_word();
    p.vx = rand_word(); p.vy = rand_word(); p.vz = rand_word();
    p.ax = rand_word(); p.ay = rand_word(); p.az = rand_word();
    p.mass = ($urandom_range(0, 7) == 0) ? 31'($urandom()) :
             31'($urandom_range(1, 1 << 18));
    if (near) begin
      p.px = 32'(ctr_q[0] + $signed($urandom_range(0, 16 << 16)) - (8 << 16));
      p.py = 32'(ctr_q[1] + $signed($urandom_range(0, 16 << 16)) - (8 << 16));
      p.pz = 32'(ctr_q[2] + $signed($urandom_range(0, 16 << 16)) - (8 << 16));
    end
    return p;
  endfunction

  task automatic test_directed();
    particle_t p;
    p = '0; p.mass = 31'd65536;
    send_particle(p);                      // zero distance
    p.px = 32'sd65536; send_particle(p);    // on axis inside
    p.px = 32'sd327680; send_particle(p);   // on the surface
    p.px = 32'sd327681; send_particle(p);   // just outside
    p = '0; p.mass = 31'd1; p.py = -32'sd65536; send_particle(p);
    p.mass = 31'h7fff_ffff; send_particle(p);
    p = '1; send_particle(p);
    p = '0; p.px = 32'h8000_0000; p.mass = 31'd1; send_particle(p); // far axis
    p = '0; p.vx = 32'h7fff_ffff; p.vy = 32'h8000_0000; p.ax = 32'h7fff_ffff;
    p.az = 32'h8000_0000; p.px = 32'h7fff_ffff; p.mass = 31'd3; send_particle(p);
    set_sphere(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 32'd65536);
    p = '0; p.px = 32'h8000_0000; p.py = 32'h7fff_ffff; p.mass = 31'd1;
    send_particle(p);
    p.pz = 32'h7fff_ffff; p.vx = 32'h8000_0000; send_particle(p);
    p = '0; p.px = 32'h8000_0000; p.py = 32'h0; p.mass = 31'd1; send_particle(p);
    set_sphere(32'h0, 32'h0, 32'h0, 32'h0, 32'd0);
    p = '0; p.mass = 31'd1; p.vx = 32'd1000; send_particle(p); // zero radius hit
    p.px = 32'd1; send_particle(p);
    set_sphere(32'hffff_0000, 32'h0001_0000, 32'h7fff_ffff, 32'hffff_ffff,
               32'h0001_ffff);
    p = '0; p.px = 32'hffff_0000; p.py = 32'h0001_1000; p.pz = 32'h7fff_0000;
    p.vx = 32'h0100_0000; p.mass = 31'h7fff_ffff; send_particle(p);
    drain();
    // unknown register index leaves the registers untouched
    cfg_we_i <= 1'b1; cfg_idx_i <= 3'd7; cfg_data_i <= '1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    send_particle(p);
  endtask

  task automatic test_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_particle(rand_particle($urandom_range(0, 3) != 0), i % 64 < 16);
  endtask

  task automatic test_backpressure();
    drain();
    rx_hold_long = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        rx_hold_long = 1'b0;
      end
      for (int i = 0; i < 250; i++) send_particle(rand_particle(1'b1), 1'b1);
    join
    drain();
  endtask

  initial begin
    ctr_q[0] = 0; ctr_q[1] = 0; ctr_q[2] = 0;
    radius_q = pscs_pkg::RadiusRst;
    dt_q = pscs_pkg::DtRst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    set_sphere(32'h0, 32'h0, 32'h0, 32'd327680, 32'd1092);
    test_random(250);
    test_backpressure();
    set_sphere(32'h0004_0000, 32'hfffc_0000, 32'h0010_0000, 32'd655360, 32'd65536);
    test_random(250);
    set_sphere($urandom(), $urandom(), $urandom(), 32'd3 << 16, 32'd30000);
    test_random(100);
    set_sphere(32'h0, 32'h0, 32'h0, 32'h7fff_ffff, 32'd1);
    test_random(150);
    drain();
    repeat (LatencyCycles + 20) @(posedge clk_i);
    if (mismatches == 0 && steps_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
